// File: design/sat_pkg.sv
// Shared types and constants for the security association table.
package sat_pkg;

	localparam int KeyW  = 64;
	localparam int AttrW = 45;

	typedef logic [KeyW-1:0]  key_t;
	typedef logic [AttrW-1:0] attr_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EXISTS   = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic {
		OP_ADD = 1'b0,
		OP_DEL = 1'b1
	} op_t;

endpackage

// File: design/sat_store.sv
// Entry storage: valid mark with key in one memory, attributes in another.
module sat_store
	import sat_pkg::*;
#(
	parameter int SLOTS = 64,
	parameter int IW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  logic          wvalid,
	input  key_t          wkey,
	input  logic          attr_we,
	input  attr_t         wattr,
	input  logic          re,
	input  logic [IW-1:0] raddr,
	output logic          rd_valid,
	output key_t          rd_key
);

	logic [KeyW:0] key_mem [SLOTS];
	attr_t         attr_mem [SLOTS];
	logic [KeyW:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr] <= {wvalid, wkey};
		end
		if (re) begin
			rd_q <= key_mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (attr_we) begin
			attr_mem[waddr] <= wattr;
		end
	end

	assign rd_valid = rd_q[KeyW];
	assign rd_key   = rd_q[KeyW-1:0];

endmodule

// File: design/security_association_table.sv
// Security association table: sequencer, key comparator and result register.
// After an input transfer the sequencer scans every slot, passes S_LAST, then commits in
// S_COMMIT and registers the result; no new item is taken until it is back in S_IDLE.
// A single compare unit scans one slot per cycle through the one read port
// of the key memory. Reset: asynchronous; a clearing pass then marks every
// slot free, during which no input is taken.
module security_association_table
	import sat_pkg::*;
#(
	parameter int SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [0:0]  op,
	input  logic [31:0] spi_value,
	input  logic [31:0] source_addr,
	input  logic [31:0] dest_addr,
	input  logic [7:0]  protocol_num,
	input  logic [0:0]  tunnel_mode,
	input  logic [1:0]  auth_kind,
	input  logic [1:0]  cipher_kind,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [5:0]  slot_index,
	output logic [6:0]  valid_count
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [IW-1:0] LastIdx = IW'(SLOTS - 1);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_LAST   = 3'd3;
	localparam logic [2:0] S_COMMIT = 3'd4;

	logic [2:0]    state_q;
	logic [IW-1:0] idx_q;
	logic          chk_s1;
	logic [IW-1:0] chk_idx_s1;
	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	logic          free_q;
	logic [IW-1:0] free_idx_q;
	logic [CW-1:0] live_q;
	op_t           op_q;
	key_t          key_q;
	attr_t         attr_q;

	logic          out_valid_q;
	status_t       status_q;
	logic [5:0]    slot_q;
	logic [6:0]    count_q;

	logic          in_xfer;
	logic          out_free;
	logic          go;
	logic          wr_ok;
	status_t       res_status;
	logic [IW-1:0] res_slot;
	logic [CW-1:0] res_count;

	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic          mem_wvalid;
	logic          attr_we;
	logic          mem_re;
	logic          rd_valid;
	key_t          rd_key;
	logic          key_eq;

	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign go       = (state_q == S_COMMIT) && out_free;

	// Shared comparator: one stored key against the item key per cycle.
	assign key_eq = chk_s1 && rd_valid && (rd_key == key_q);

	always_comb begin
		res_status = ST_OK;
		res_slot   = '0;
		res_count  = live_q;
		wr_ok      = 1'b0;
		unique case (op_q)
			OP_ADD: begin
				if (hit_q) begin
					res_status = ST_EXISTS;
				end else if (!free_q) begin
					res_status = ST_FULL;
				end else begin
					wr_ok     = 1'b1;
					res_slot  = free_idx_q;
					res_count = live_q + CW'(1);
				end
			end
			OP_DEL: begin
				if (!hit_q) begin
					res_status = ST_NOTFOUND;
				end else begin
					wr_ok     = 1'b1;
					res_slot  = hit_idx_q;
					res_count = live_q - CW'(1);
				end
			end
			default: begin
				res_status = ST_OK;
			end
		endcase
	end

	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = idx_q;
		mem_wvalid = 1'b0;
		attr_we    = 1'b0;
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
		end else if (go && wr_ok) begin
			mem_we     = 1'b1;
			mem_waddr  = res_slot;
			mem_wvalid = (op_q == OP_ADD);
			attr_we    = (op_q == OP_ADD);
		end
	end

	assign mem_re = (state_q == S_SCAN);

	sat_store #(
		.SLOTS (SLOTS),
		.IW    (IW)
	) u_store (
		.clk      (clk),
		.we       (mem_we),
		.waddr    (mem_waddr),
		.wvalid   (mem_wvalid),
		.wkey     (key_q),
		.attr_we  (attr_we),
		.wattr    (attr_q),
		.re       (mem_re),
		.raddr    (idx_q),
		.rd_valid (rd_valid),
		.rd_key   (rd_key)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			idx_q      <= '0;
			chk_s1     <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			live_q     <= '0;
		end else begin
			chk_s1 <= (state_q == S_SCAN);
			if (key_eq && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (chk_s1 && !rd_valid && !free_q) begin
				free_q <= 1'b1;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (idx_q == LastIdx) begin
						idx_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				S_IDLE: begin
					if (in_xfer) begin
						idx_q   <= '0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (idx_q == LastIdx) begin
						idx_q   <= '0;
						state_q <= S_LAST;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				S_LAST: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (go) begin
						live_q  <= res_count;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= idx_q;
		if (key_eq && !hit_q) begin
			hit_idx_q <= chk_idx_s1;
		end
		if (chk_s1 && !rd_valid && !free_q) begin
			free_idx_q <= chk_idx_s1;
		end
		if (in_xfer) begin
			op_q   <= op_t'(op);
			key_q  <= {spi_value, dest_addr};
			attr_q <= {source_addr, protocol_num, tunnel_mode, auth_kind, cipher_kind};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			status_q <= res_status;
			slot_q   <= 6'(res_slot);
			count_q  <= 7'(res_count);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign slot_index  = slot_q;
	assign valid_count = count_q;

endmodule
